### rtl/core/decade_bucket_mlfq_scheduler_assert.svh
// assertion macros for the decade bucket scheduler
`ifndef DECADE_BUCKET_MLFQ_SCHEDULER_ASSERT_SVH
`define DECADE_BUCKET_MLFQ_SCHEDULER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define DBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/dbm_pkg.sv
// shared types and constants for the decade bucket scheduler
package dbm_pkg;
	localparam int FIFO_DEPTH = 256;
	localparam int HEAP_DEPTH = 256;
	localparam int LEVELS = 5;
	localparam int NUM_THRESH = 5;
	localparam int FAW = $clog2(FIFO_DEPTH);
	localparam int HAW = $clog2(HEAP_DEPTH);
	localparam int LVW = $clog2(LEVELS);
	localparam int FMW = $clog2(LEVELS * FIFO_DEPTH);
	localparam int STW = 24;
	localparam int HEW = 16 + 32 + STW;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_GET = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_FADD, S_FRD, S_FRD2, S_HPUSH,
		S_UPRD, S_UPCMP, S_HPOP, S_HLAST, S_DNRD, S_DNRD2, S_DNCMP,
		S_TOPRD, S_TOPWT, S_DONE, S_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] avg;
		logic [STW-1:0] stamp;
	} hentry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic fadd;
		logic frd;
		logic fpop;
		logic hpush;
		logic uprd;
		logic upswap;
		logic hpop;
		logic hlast;
		logic dnrd;
		logic dnrd2;
		logic dnswap;
		logic toprd;
		logic topcap;
		logic clear;
		logic finish;
		logic [1:0] st;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ignore;
		logic to_heap;
		logic zero_avg;
		logic heap_full;
		logic lvl_full;
		logic fifo_any;
		logic heap_any;
		logic up_more;
		logic up_swap;
		logic dn_left;
		logic dn_swap;
		logic hempty_after;
	} stat_t;

	function automatic logic above(hentry_t a, hentry_t b);
		if (a.avg != b.avg) return a.avg > b.avg;
		return a.stamp < b.stamp;
	endfunction
endpackage

### rtl/core/dbm_if.sv
// valid/ready channel interfaces for the scheduler
interface dbm_in_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [15:0] item_id;
	logic [31:0] priority_req;
	logic [31:0] average;
	logic force_zero;
	modport source(output valid, mode, item_id, priority_req, average, force_zero,
		input ready);
	modport sink(input valid, mode, item_id, priority_req, average, force_zero,
		output ready);
endinterface

interface dbm_out_if;
	logic valid;
	logic ready;
	logic [15:0] out_id;
	logic [1:0] status;
	logic from_heap;
	logic [10:0] fifo_count;
	logic [8:0] heap_count;
	logic [31:0] heap_top_average;
	modport source(output valid, out_id, status, from_heap, fifo_count, heap_count,
		heap_top_average, input ready);
	modport sink(input valid, out_id, status, from_heap, fifo_count, heap_count,
		heap_top_average, output ready);
endinterface

interface dbm_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/dbm_ctrl.sv
// controller state machine for the scheduler
module dbm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input logic [1:0] mode,
	input dbm_pkg::stat_t st,
	output dbm_pkg::cmd_t cmd
);
	import dbm_pkg::*;

	state_t state_q, state_d;
	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_NONE;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) mode_q <= mode_t'(mode);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (mode_q)
					MODE_ADD: begin
						if (st.ignore) state_d = S_DONE;
						else if (st.to_heap) begin
							if (st.zero_avg || st.heap_full) state_d = S_DONE;
							else state_d = S_HPUSH;
						end else if (st.lvl_full) state_d = S_DONE;
						else state_d = S_FADD;
					end
					MODE_GET: begin
						if (st.fifo_any) state_d = S_FRD;
						else if (st.heap_any) state_d = S_HPOP;
						else state_d = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FADD: state_d = S_DONE;
			S_FRD: state_d = S_FRD2;
			S_FRD2: state_d = S_DONE;
			S_HPUSH: state_d = S_UPRD;
			S_UPRD: state_d = st.up_more ? S_UPCMP : S_TOPRD;
			S_UPCMP: state_d = st.up_swap ? S_UPRD : S_TOPRD;
			S_HPOP: state_d = st.hempty_after ? S_DONE : S_HLAST;
			S_HLAST: state_d = S_DNRD;
			S_DNRD: state_d = st.dn_left ? S_DNRD2 : S_TOPRD;
			S_DNRD2: state_d = S_DNCMP;
			S_DNCMP: state_d = st.dn_swap ? S_DNRD : S_TOPRD;
			S_TOPRD: state_d = S_TOPWT;
			S_TOPWT: state_d = S_DONE;
			S_DONE: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		cmd.capture = in_valid && (state_q == S_IDLE);
		unique case (state_q)
			S_DECODE: begin
				cmd.st = ST_OK;
				unique case (mode_q)
					MODE_ADD: begin
						if (st.ignore) cmd.st = ST_IGNORED;
						else if (st.to_heap) begin
							if (st.zero_avg) cmd.st = ST_IGNORED;
							else if (st.heap_full) cmd.st = ST_FULL;
						end else if (st.lvl_full) cmd.st = ST_FULL;
					end
					MODE_GET: if (!st.fifo_any && !st.heap_any) cmd.st = ST_EMPTY;
					MODE_CLEAR: cmd.clear = 1'b1;
					default: cmd.st = ST_IGNORED;
				endcase
			end
			S_FADD: cmd.fadd = 1'b1;
			S_FRD: cmd.frd = 1'b1;
			S_FRD2: cmd.fpop = 1'b1;
			S_HPUSH: cmd.hpush = 1'b1;
			S_UPRD: cmd.uprd = 1'b1;
			S_UPCMP: cmd.upswap = st.up_swap;
			S_HPOP: cmd.hpop = 1'b1;
			S_HLAST: cmd.hlast = 1'b1;
			S_DNRD: cmd.dnrd = 1'b1;
			S_DNRD2: cmd.dnrd2 = 1'b1;
			S_DNCMP: cmd.dnswap = st.dn_swap;
			S_TOPRD: cmd.toprd = 1'b1;
			S_TOPWT: cmd.topcap = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end
endmodule

### rtl/core/dbm_datapath.sv
// fifo levels, heap store and result registers
module dbm_datapath (
	input logic clk,
	input logic arst_n,
	input dbm_pkg::cmd_t cmd,
	output dbm_pkg::stat_t st,
	input logic [15:0] item_id,
	input logic [31:0] priority_req,
	input logic [31:0] average,
	input logic force_zero,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic [15:0] out_id,
	output logic [1:0] out_status,
	output logic out_from_heap,
	output logic [10:0] fifo_count,
	output logic [8:0] heap_count,
	output logic [31:0] heap_top_average
);
	import dbm_pkg::*;

	logic [31:0] thr_q [NUM_THRESH];
	logic [15:0] id_q;
	logic [31:0] prio_q, avg_q;
	logic force_q;

	logic [15:0] fmem [LEVELS * FIFO_DEPTH];
	logic [15:0] frd_q;
	logic [FAW-1:0] head_q [LEVELS];
	logic [FAW-1:0] tail_q [LEVELS];
	logic [FAW:0] cnt_q [LEVELS];
	logic [LVW-1:0] hi_q;
	logic hi_valid_q;
	logic [10:0] ftotal_q;

	hentry_t hmem [HEAP_DEPTH];
	hentry_t rd_a_q, rd_b_q, cur_q;
	logic [HAW:0] hsize_q;
	logic [STW-1:0] stamp_q;
	logic [HAW-1:0] idx_q;
	logic [31:0] top_avg_q;
	logic [1:0] st_q;
	logic [15:0] oid_q;
	logic fh_q;

	// threshold compare for target level
	logic [LVW-1:0] lvl;
	always_comb begin
		lvl = '0;
		for (int i = 1; i < LEVELS && i < NUM_THRESH; i++)
			if (prio_q >= thr_q[i]) lvl = LVW'(i);
	end

	// next-lower non-empty level after a pop
	logic [LVW-1:0] nxt_lvl;
	logic nxt_valid;
	always_comb begin
		nxt_lvl = '0;
		nxt_valid = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (LVW'(i) < hi_q && cnt_q[i] != '0) begin
				nxt_lvl = LVW'(i);
				nxt_valid = 1'b1;
			end
		end
	end

	logic [HAW:0] par_w, lch_w, rch_w;
	assign par_w = ({1'b0, idx_q} - 1'b1) >> 1;
	assign lch_w = {idx_q, 1'b1};
	assign rch_w = lch_w + 1'b1;

	hentry_t best_e;
	logic use_right;
	assign use_right = (rch_w < hsize_q) && above(rd_b_q, rd_a_q);
	assign best_e = use_right ? rd_b_q : rd_a_q;

	assign st.ignore = (prio_q == '0) && !force_q;
	assign st.to_heap = prio_q < thr_q[0];
	assign st.zero_avg = (avg_q == '0);
	assign st.heap_full = (hsize_q >= (HAW+1)'(HEAP_DEPTH));
	assign st.lvl_full = (cnt_q[lvl] >= (FAW+1)'(FIFO_DEPTH));
	assign st.fifo_any = hi_valid_q;
	assign st.heap_any = (hsize_q != '0);
	assign st.up_more = (idx_q != '0);
	assign st.up_swap = above(cur_q, rd_a_q);
	assign st.dn_left = (lch_w < hsize_q);
	assign st.dn_swap = above(best_e, cur_q);
	assign st.hempty_after = (hsize_q == (HAW+1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[0] <= 32'd66;
			thr_q[1] <= 32'd655;
			thr_q[2] <= 32'd6554;
			thr_q[3] <= 32'd65536;
			thr_q[4] <= 32'd655360;
		end else if (cfg_we && cfg_index < 3'(NUM_THRESH)) begin
			thr_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= item_id;
			prio_q <= priority_req;
			avg_q <= average;
			force_q <= force_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fadd) fmem[{lvl, tail_q[lvl]}] <= id_q;
		if (cmd.frd) frd_q <= fmem[{hi_q, head_q[hi_q]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			hi_q <= '0;
			hi_valid_q <= 1'b0;
			ftotal_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			hi_q <= '0;
			hi_valid_q <= 1'b0;
			ftotal_q <= '0;
		end else if (cmd.fadd) begin
			tail_q[lvl] <= tail_q[lvl] + 1'b1;
			cnt_q[lvl] <= cnt_q[lvl] + 1'b1;
			ftotal_q <= ftotal_q + 1'b1;
			if (!hi_valid_q || lvl > hi_q) hi_q <= lvl;
			hi_valid_q <= 1'b1;
		end else if (cmd.fpop) begin
			head_q[hi_q] <= head_q[hi_q] + 1'b1;
			cnt_q[hi_q] <= cnt_q[hi_q] - 1'b1;
			ftotal_q <= ftotal_q - 1'b1;
			if (cnt_q[hi_q] == (FAW+1)'(1)) begin
				hi_q <= nxt_lvl;
				hi_valid_q <= nxt_valid;
			end
		end
	end

	// pop needs the last entry as the new root candidate
	hentry_t last_q;
	always_ff @(posedge clk) begin
		if (cmd.hpop) last_q <= hmem[HAW'(hsize_q - 1'b1)];
	end

	// heap store, one write port; sift reads share one read port, a pop also reads the last entry above
	always_ff @(posedge clk) begin
		if (cmd.hpush) hmem[hsize_q[HAW-1:0]] <= '{id: id_q, avg: avg_q, stamp: stamp_q};
		else if (cmd.upswap) begin
			hmem[idx_q] <= rd_a_q;
		end else if (cmd.hlast) hmem[0] <= last_q;
		else if (cmd.dnswap) hmem[idx_q] <= best_e;
		else if (cmd.topcap && !cmd.hpop) hmem[idx_q] <= cur_q;
		if (cmd.hpop) rd_a_q <= hmem[0];
		else if (cmd.hlast) rd_b_q <= hmem[0];
		else if (cmd.uprd) rd_a_q <= hmem[par_w[HAW-1:0]];
		else if (cmd.dnrd) rd_a_q <= hmem[lch_w[HAW-1:0]];
		else if (cmd.dnrd2) rd_b_q <= hmem[rch_w[HAW-1:0]];
		else if (cmd.toprd) rd_b_q <= hmem[0];
	end

	// the moving entry stays in cur_q, written home once sifting stops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsize_q <= '0;
			stamp_q <= '0;
			idx_q <= '0;
			top_avg_q <= '0;
			st_q <= ST_OK;
			oid_q <= '0;
			fh_q <= 1'b0;
			cur_q <= '0;
		end else begin
			if (cmd.capture) begin
				st_q <= ST_OK;
				oid_q <= '0;
				fh_q <= 1'b0;
			end
			if (cmd.clear) begin
				hsize_q <= '0;
				stamp_q <= '0;
				top_avg_q <= '0;
			end
			if (!cmd.clear && cmd.st != ST_OK) st_q <= cmd.st;
			if (cmd.fpop) oid_q <= frd_q;
			if (cmd.hpush) begin
				cur_q <= '{id: id_q, avg: avg_q, stamp: stamp_q};
				idx_q <= hsize_q[HAW-1:0];
				hsize_q <= hsize_q + 1'b1;
				stamp_q <= stamp_q + 1'b1;
			end
			if (cmd.upswap) idx_q <= par_w[HAW-1:0];
			if (cmd.hpop) begin
				hsize_q <= hsize_q - 1'b1;
				fh_q <= 1'b1;
				idx_q <= (hsize_q - 1'b1) >= (HAW+1)'(HEAP_DEPTH) ?
					'0 : HAW'(hsize_q - 1'b1);
				if (hsize_q == (HAW+1)'(1)) top_avg_q <= '0;
			end
			if (cmd.hlast) begin
				oid_q <= rd_a_q.id;
				idx_q <= '0;
				cur_q <= last_q;
			end
			// single-entry pop: id comes straight from the read
			if (cmd.finish && fh_q && hsize_q == '0) oid_q <= rd_a_q.id;
			if (cmd.dnswap) idx_q <= use_right ? rch_w[HAW-1:0] : lch_w[HAW-1:0];
			if (cmd.topcap) top_avg_q <= (idx_q == '0) ? cur_q.avg : rd_b_q.avg;
		end
	end

	assign out_id = oid_q;
	assign out_status = st_q;
	assign out_from_heap = fh_q;
	assign fifo_count = ftotal_q;
	assign heap_count = 9'(hsize_q);
	assign heap_top_average = (hsize_q == '0) ? 32'd0 : top_avg_q;
endmodule

### rtl/core/decade_bucket_mlfq_scheduler.sv
// top level of the decade bucket multi-level queue scheduler
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | mode, item_id, priority_req, average, force_zero
//  out_ch  | out | valid/ready       | out_id, status, from_heap, counts, top average
//  cfg_ch  | in  | valid/ready       | index, data (thresholds 0..4)
// one transaction at a time; ignored, dropped, empty-get, clear or unused-mode requests
// go from decode straight to the result; a fifo add passes S_FADD, a fifo get S_FRD
// and S_FRD2; a heap push repeats S_UPRD and S_UPCMP per level climbed, a heap pop
// repeats S_DNRD, S_DNRD2 and S_DNCMP per level descended, as the store has one read port
// reset clears all counts and pointers; store contents need no clearing
// a result held by the output stalls the next input transaction
module decade_bucket_mlfq_scheduler (
	input logic clk,
	input logic arst_n,
	dbm_in_if.sink in_ch,
	dbm_out_if.source out_ch,
	dbm_cfg_if.sink cfg_ch
);
	import dbm_pkg::*;
	`include "decade_bucket_mlfq_scheduler_assert.svh"

	cmd_t cmd;
	stat_t st;
	logic [1:0] status_w;

	assign cfg_ch.ready = 1'b1;

	dbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.mode(in_ch.mode), .st(st), .cmd(cmd)
	);

	dbm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.item_id(in_ch.item_id), .priority_req(in_ch.priority_req),
		.average(in_ch.average), .force_zero(in_ch.force_zero),
		.cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
		.out_id(out_ch.out_id), .out_status(status_w), .out_from_heap(out_ch.from_heap),
		.fifo_count(out_ch.fifo_count), .heap_count(out_ch.heap_count),
		.heap_top_average(out_ch.heap_top_average)
	);
	assign out_ch.status = status_w;

	`DBM_ASSERT_IMP(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready, "input taken while result pending")
	`DBM_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, out_ch.fifo_count <= 11'd1280, "fifo count overflow")
	`DBM_ASSERT_IMP(a_heap_bound, clk, arst_n, 1'b1, out_ch.heap_count <= 9'd256, "heap count overflow")
	`DBM_ASSERT_IMP(a_heap_flag, clk, arst_n, out_ch.valid && out_ch.from_heap, out_ch.status == ST_OK, "heap pop flagged with bad status")
endmodule

### test/decade_bucket_mlfq_scheduler_tb_if.sv
`timescale 1ns / 100ps
// result record shared by the scheduler testbench
package dbm_tb_pkg;
	import dbm_pkg::*;
	typedef struct {
		logic [15:0] out_id;
		status_t status;
		logic from_heap;
		logic [10:0] fifo_count;
		logic [8:0] heap_count;
		logic [31:0] top_avg;
	} sched_result_t;
endpackage

### test/decade_bucket_mlfq_scheduler_tb.sv
`timescale 1ns / 100ps
// testbench for the decade bucket scheduler: random and directed traffic against a local predictor
module decade_bucket_mlfq_scheduler_tb;
	import dbm_pkg::*;
	import dbm_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int idle_cycles = 0;
	bit sink_hold = 1'b0;

	dbm_in_if in_ch();
	dbm_out_if out_ch();
	dbm_cfg_if cfg_ch();

	decade_bucket_mlfq_scheduler i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [31:0] thr [NUM_THRESH];
	logic [15:0] lq_id [LEVELS][$];
	int top_lvl;
	logic [15:0] hp_id [HEAP_DEPTH];
	logic [31:0] hp_avg [HEAP_DEPTH];
	logic [23:0] hp_stamp [HEAP_DEPTH];
	int hp_size;
	logic [23:0] stamp_ctr;
	sched_result_t expected_results [$];

	function automatic bit hp_higher(int a, int b);
		if (hp_avg[a] != hp_avg[b]) return hp_avg[a] > hp_avg[b];
		return hp_stamp[a] < hp_stamp[b];
	endfunction

	function automatic void hp_swap(int a, int b);
		logic [15:0] ti;
		logic [31:0] ta;
		logic [23:0] ts;
		ti = hp_id[a]; ta = hp_avg[a]; ts = hp_stamp[a];
		hp_id[a] = hp_id[b]; hp_avg[a] = hp_avg[b]; hp_stamp[a] = hp_stamp[b];
		hp_id[b] = ti; hp_avg[b] = ta; hp_stamp[b] = ts;
	endfunction

	function automatic void wipe_sched();
		for (int l = 0; l < LEVELS; l++) lq_id[l].delete();
		top_lvl = -1;
		hp_size = 0;
		stamp_ctr = '0;
	endfunction

	function automatic status_t file_item(logic [15:0] id, logic [31:0] prio,
			logic [31:0] avg, logic frc);
		int lvl;
		int i;
		int p;
		lvl = 0;
		if (prio == 0 && !frc) return ST_IGNORED;
		if (prio < thr[0]) begin
			if (avg == 0) return ST_IGNORED;
			if (hp_size >= HEAP_DEPTH) return ST_FULL;
			i = hp_size;
			hp_id[i] = id; hp_avg[i] = avg; hp_stamp[i] = stamp_ctr;
			stamp_ctr++;
			hp_size++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!hp_higher(i, p)) break;
				hp_swap(i, p);
				i = p;
			end
			return ST_OK;
		end
		for (int k = 1; k < LEVELS; k++)
			if (prio >= thr[k]) lvl = k;
		if (lq_id[lvl].size() >= FIFO_DEPTH) return ST_FULL;
		lq_id[lvl].insert(lq_id[lvl].size(), id);
		if (lvl > top_lvl) top_lvl = lvl;
		return ST_OK;
	endfunction

	function automatic sched_result_t schedule_step(mode_t md, logic [15:0] id,
			logic [31:0] prio, logic [31:0] avg, logic frc);
		sched_result_t r;
		int i;
		int l;
		int rr;
		int best;
		r.out_id = '0;
		r.status = ST_OK;
		r.from_heap = 1'b0;
		r.fifo_count = '0;
		r.heap_count = '0;
		r.top_avg = '0;
		case (md)
			MODE_ADD: r.status = file_item(id, prio, avg, frc);
			MODE_GET: begin
				if (top_lvl >= 0) begin
					r.out_id = lq_id[top_lvl].pop_front();
					while (top_lvl >= 0 && lq_id[top_lvl].size() == 0) top_lvl--;
				end else if (hp_size > 0) begin
					r.out_id = hp_id[0];
					r.from_heap = 1'b1;
					hp_size--;
					if (hp_size > 0) begin
						hp_id[0] = hp_id[hp_size]; hp_avg[0] = hp_avg[hp_size];
						hp_stamp[0] = hp_stamp[hp_size];
					end
					i = 0;
					forever begin
						l = 2 * i + 1; rr = l + 1; best = i;
						if (l < hp_size && hp_higher(l, best)) best = l;
						if (rr < hp_size && hp_higher(rr, best)) best = rr;
						if (best == i) break;
						hp_swap(i, best);
						i = best;
					end
				end else r.status = ST_EMPTY;
			end
			MODE_CLEAR: wipe_sched();
			default: r.status = ST_IGNORED;
		endcase
		for (int k = 0; k < LEVELS; k++) r.fifo_count += 11'(lq_id[k].size());
		r.heap_count = 9'(hp_size);
		r.top_avg = hp_size > 0 ? hp_avg[0] : 32'd0;
		return r;
	endfunction

	// stimulus
	task automatic send_request(mode_t md, logic [15:0] id, logic [31:0] prio,
			logic [31:0] avg, logic frc);
		in_ch.valid <= 1'b1;
		in_ch.mode <= md;
		in_ch.item_id <= id;
		in_ch.priority_req <= prio;
		in_ch.average <= avg;
		in_ch.force_zero <= frc;
		do @(posedge clk); while (!in_ch.ready);
		expected_results.insert(expected_results.size(),
			schedule_step(md, id, prio, avg, frc));
		@(negedge clk);
		// bursts with random gaps
		if ($urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_thresh(int idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx[2:0];
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		thr[idx] = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_prio();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return $urandom_range(1, 65);
			2: return $urandom_range(66, 700);
			3: return $urandom_range(600, 7000);
			4: return $urandom_range(6000, 70000);
			5: return $urandom_range(600000, 2000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_ops(int n, int add_weight);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < add_weight)
				send_request(MODE_ADD, 16'($urandom), rand_prio(),
					($urandom_range(0, 9) == 0) ? 32'd0 : ($urandom_range(0, 1) ?
					$urandom_range(0, 15) : $urandom), 1'($urandom_range(0, 1)));
			else if (pick < 98)
				send_request(MODE_GET, 16'($urandom), $urandom, $urandom, 1'b0);
			else if (pick == 98)
				send_request(MODE_CLEAR, 16'($urandom), $urandom, $urandom, 1'b0);
			else send_request(MODE_NONE, 16'($urandom), $urandom, $urandom, 1'b1);
		end
	endtask

	task automatic test_directed();
		send_request(MODE_GET, 16'h0, 32'd0, 32'd0, 1'b0);
		send_request(MODE_ADD, 16'h1234, 32'd0, 32'd5, 1'b0);
		send_request(MODE_ADD, 16'hFFFF, 32'd0, 32'd7, 1'b1);
		send_request(MODE_ADD, 16'h0001, 32'd10, 32'd0, 1'b0);
		send_request(MODE_ADD, 16'h0002, 32'd10, 32'd7, 1'b0);
		send_request(MODE_ADD, 16'h0003, 32'd65, 32'hFFFF_FFFF, 1'b0);
		send_request(MODE_ADD, 16'h0004, 32'd66, 32'd1, 1'b0);
		send_request(MODE_ADD, 16'h0005, 32'd655, 32'd1, 1'b0);
		send_request(MODE_ADD, 16'h0006, 32'd6554, 32'd1, 1'b0);
		send_request(MODE_ADD, 16'h0007, 32'd65536, 32'd1, 1'b0);
		send_request(MODE_ADD, 16'h0008, 32'hFFFF_FFFF, 32'd1, 1'b0);
		send_request(MODE_NONE, 16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		repeat (9) send_request(MODE_GET, 16'h0, 32'd0, 32'd0, 1'b0);
		send_request(MODE_ADD, 16'h0009, 32'd1, 32'd3, 1'b0);
		send_request(MODE_CLEAR, 16'h0, 32'd0, 32'd0, 1'b0);
		send_request(MODE_GET, 16'h0, 32'd0, 32'd0, 1'b0);
		settle();
	endtask

	task automatic test_full_stores();
		// fill one fifo level past depth, then the heap past depth and drain it
		for (int k = 0; k < FIFO_DEPTH + 2; k++)
			send_request(MODE_ADD, k[15:0], 32'd100, 32'd1, 1'b0);
		repeat (2) send_request(MODE_GET, 16'h0, 32'd0, 32'd0, 1'b0);
		send_request(MODE_CLEAR, 16'h0, 32'd0, 32'd0, 1'b0);
		for (int k = 0; k < HEAP_DEPTH + 2; k++)
			send_request(MODE_ADD, 16'($urandom), 32'd1, $urandom_range(1, 4), 1'b0);
		for (int k = 0; k < HEAP_DEPTH + 2; k++)
			send_request(MODE_GET, 16'h0, 32'd0, 32'd0, 1'b0);
		settle();
	endtask

	task automatic test_back_pressure();
		sink_hold = 1'b1;
		random_ops(20, 80);
		settle();
	endtask

	task automatic test_thresholds();
		write_thresh(0, 32'd0);
		write_thresh(1, 32'hFFFF_FFFF);
		write_thresh(2, 32'hFFFF_FFFF);
		write_thresh(3, 32'd0);
		write_thresh(4, 32'hFFFF_FFFF);
		random_ops(40, 60);
		send_request(MODE_CLEAR, 16'h0, 32'd0, 32'd0, 1'b0);
		settle();
		write_thresh(0, 32'hFFFF_FFFF);
		random_ops(40, 60);
		send_request(MODE_CLEAR, 16'h0, 32'd0, 32'd0, 1'b0);
		settle();
		write_thresh(0, 32'd66);
		write_thresh(1, 32'd655);
		write_thresh(2, 32'd6554);
		write_thresh(3, 32'd65536);
		write_thresh(4, 32'd655360);
		settle();
	endtask

	task automatic test_random();
		random_ops(80, 60);
		random_ops(40, 35);
		settle();
	endtask

	// result checking
	always @(posedge clk) begin
		sched_result_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_ch.out_id !== e.out_id) begin
					$error("out_id exp %0h got %0h", e.out_id, out_ch.out_id); errors++;
				end
				if (out_ch.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_ch.status); errors++;
				end
				if (out_ch.from_heap !== e.from_heap) begin
					$error("from_heap exp %0d got %0d", e.from_heap, out_ch.from_heap);
					errors++;
				end
				if (out_ch.fifo_count !== e.fifo_count) begin
					$error("fifo_count exp %0d got %0d", e.fifo_count, out_ch.fifo_count);
					errors++;
				end
				if (out_ch.heap_count !== e.heap_count) begin
					$error("heap_count exp %0d got %0d", e.heap_count, out_ch.heap_count);
					errors++;
				end
				if (out_ch.heap_top_average !== e.top_avg) begin
					$error("heap_top_average exp %0h got %0h", e.top_avg,
						out_ch.heap_top_average);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(negedge clk) begin
		if (sink_hold) begin
			out_ch.ready <= 1'b0;
			repeat (400) @(negedge clk);
			sink_hold = 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_ADD;
		in_ch.item_id = '0;
		in_ch.priority_req = '0;
		in_ch.average = '0;
		in_ch.force_zero = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		thr[0] = 32'd66; thr[1] = 32'd655; thr[2] = 32'd6554;
		thr[3] = 32'd65536; thr[4] = 32'd655360;
		wipe_sched();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_stores();
		test_back_pressure();
		test_thresholds();
		test_random();
		if (errors == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/dbm_pkg.sv
rtl/core/dbm_if.sv
rtl/core/dbm_ctrl.sv
rtl/core/dbm_datapath.sv
rtl/core/decade_bucket_mlfq_scheduler.sv
test/decade_bucket_mlfq_scheduler_tb_if.sv
test/decade_bucket_mlfq_scheduler_tb.sv
